@@ rtl/text_console_cell_writer_top_defines.svh @@
// Assertion helpers shared by the console RTL.
// Each expects i_clk and i_rst_n in the scope that uses it.
`ifndef TEXT_CONSOLE_CELL_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CELL_WRITER_TOP_DEFINES_SVH

// Same-cycle implication.
`define TCCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tccw_pkg.sv @@
package tccw_pkg;

    // field widths
    localparam int KIND_W = 2;
    localparam int CODE_W = 8;
    localparam int IDX_W  = 11;
    localparam int CELL_W = 16;
    localparam int POS_W  = 11;
    localparam int ATTR_W = 8;

    // stream and register port widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 2;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0000;

    // register addresses
    localparam logic [APB_AW-1:0] ADDR_ATTRIBUTE = 2'd0;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CODE_W-1:0] code;
        logic [IDX_W-1:0]  idx;
    } t_item;

    typedef struct packed {
        logic [CELL_W-1:0] value;
        logic [POS_W-1:0]  pos;
    } t_result;

endpackage

@@ rtl/tccw_core.sv @@
`include "text_console_cell_writer_top_defines.svh"

module tccw_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  tccw_pkg::t_item             i_item,
    input  logic [tccw_pkg::ATTR_W-1:0] i_attr,
    input  logic                        i_out_free,
    output logic                        o_idle,
    output logic                        o_done,
    output tccw_pkg::t_result           o_result
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int NCOPY = CELLS - COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int CMP_W = (CW > tccw_pkg::IDX_W) ? CW : tccw_pkg::IDX_W;

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_CLEAR  = 3'd2;
    localparam logic [2:0] ST_SCROLL = 3'd3;
    localparam logic [2:0] ST_BLANK  = 3'd4;
    localparam logic [2:0] ST_READ   = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [CW-1:0]    r_base, n_base;
    logic             r_rd_ok, n_rd_ok;
    logic [tccw_pkg::CELL_W-1:0] r_val, n_val;

    logic [tccw_pkg::CELL_W-1:0] r_mem [CELLS];
    logic [tccw_pkg::CELL_W-1:0] r_rd_data;

    logic [CW-1:0] add_a, add_b, sum;
    logic [CW-1:0] cnt_inc, cnt_m1;
    logic          last_cell;
    logic          in_range;
    logic          put_char;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [tccw_pkg::CELL_W-1:0] mem_wdata;
    logic [AW-1:0]               mem_raddr;

    // shared address adder: cursor address, or copy source during scroll
    always_comb begin
        add_a = r_base;
        add_b = CW'(r_col);
        if (r_state == ST_SCROLL) begin
            add_a = r_cnt;
            add_b = CW'(COLUMNS);
        end
    end
    assign sum = add_a + add_b;

    assign cnt_inc   = r_cnt + CW'(1);
    assign cnt_m1    = r_cnt - CW'(1);
    assign last_cell = (r_cnt == CW'(CELLS - 1));
    assign in_range  = (CMP_W'(i_item.idx) < CMP_W'(CELLS));
    assign put_char  = (i_item.kind == tccw_pkg::KIND_PUT)
                       && (i_item.code != tccw_pkg::NEWLINE_CODE);

    // buffer port selection
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cnt[AW-1:0];
        mem_wdata = tccw_pkg::BLANK_CELL;
        mem_raddr = AW'(i_item.idx);
        unique case (r_state) inside
            ST_INIT, ST_CLEAR, ST_BLANK: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                if (i_start && put_char) begin
                    mem_we    = 1'b1;
                    mem_waddr = sum[AW-1:0];
                    mem_wdata = {i_attr, i_item.code};
                end
            end
            ST_SCROLL: begin
                // read row below, write it one row up in the following cycle
                mem_we    = (r_cnt != '0);
                mem_waddr = cnt_m1[AW-1:0];
                mem_wdata = r_rd_data;
                mem_raddr = (r_cnt < CW'(NCOPY)) ? sum[AW-1:0] : '0;
            end
            default: begin
            end
        endcase
    end

    // screen buffer
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_col   = r_col;
        n_row   = r_row;
        n_base  = r_base;
        n_rd_ok = r_rd_ok;
        n_val   = r_val;
        unique case (r_state)
            ST_INIT: begin
                n_cnt = cnt_inc;
                if (last_cell) begin
                    n_state = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                n_cnt = cnt_inc;
                if (last_cell) begin
                    n_state = ST_DONE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_DONE;
                    n_rd_ok = in_range;
                    n_val   = tccw_pkg::BLANK_CELL;
                    case (i_item.kind)
                        tccw_pkg::KIND_PUT: begin
                            if (put_char && (r_col != COL_W'(COLUMNS - 1))) begin
                                n_col = r_col + COL_W'(1);
                            end else begin
                                // newline or wrap
                                n_col = '0;
                                if (r_row == ROW_W'(ROWS - 1)) begin
                                    n_state = ST_SCROLL;
                                    n_cnt   = '0;
                                end else begin
                                    n_row  = r_row + ROW_W'(1);
                                    n_base = r_base + CW'(COLUMNS);
                                end
                            end
                        end
                        tccw_pkg::KIND_READ: begin
                            n_state = ST_READ;
                        end
                        tccw_pkg::KIND_CLEAR: begin
                            n_state = ST_CLEAR;
                            n_cnt   = '0;
                            n_col   = '0;
                            n_row   = '0;
                            n_base  = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_val   = r_rd_ok ? r_rd_data : tccw_pkg::BLANK_CELL;
                n_state = ST_DONE;
            end
            ST_SCROLL: begin
                if (r_cnt == CW'(NCOPY)) begin
                    // last copy write goes out now; blanking starts at the bottom row
                    n_state = ST_BLANK;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            ST_BLANK: begin
                n_cnt = cnt_inc;
                if (last_cell) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_cnt   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_base  <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_col   <= n_col;
            r_row   <= n_row;
            r_base  <= n_base;
            r_rd_ok <= n_rd_ok;
        end
        r_val <= n_val;
    end

    assign o_idle         = (r_state == ST_IDLE);
    assign o_done         = (r_state == ST_DONE) && i_out_free;
    assign o_result.value = r_val;
    assign o_result.pos   = tccw_pkg::POS_W'(sum);

    `TCCW_ASSERT_NOW(a_waddr_range, mem_we, ({1'b0, mem_waddr} < (AW+1)'(CELLS)), "buffer write out of range")
    `TCCW_ASSERT_NOW(a_cursor_range, 1'b1, (({1'b0, r_col} < (COL_W+1)'(COLUMNS)) && ({1'b0, r_row} < (ROW_W+1)'(ROWS))), "cursor out of range")
    `TCCW_ASSERT_NOW(a_base_match, 1'b1, (r_base == CW'(r_row * COLUMNS)), "row base does not match cursor row")
    `TCCW_ASSERT_NEXT(a_scroll_to_blank, ((r_state == ST_SCROLL) && (r_cnt == CW'(NCOPY))), ((r_state == ST_BLANK) && (r_cnt == CW'(NCOPY))), "scroll did not hand off to bottom row blank")

endmodule

@@ rtl/text_console_cell_writer_top.sv @@
// Text console cell writer: a COLUMNS x ROWS buffer of 16-bit cells
// (attribute in bits 15..8, character in 7..0) with a cursor. One item is
// in work at a time; s_axis_tready is high only while the sequencer is idle.
// A printable put, a newline or kind 3 passes from idle to done, a read
// goes through a read state first; done waits for the output register to drain.
// A put or newline that leaves the last row scrolls: the copy steps move
// COLUMNS*(ROWS-1) cells up one row through the buffer, then COLUMNS cells
// of the bottom row are blanked. A clear walks the buffer one cell a cycle.
// After reset the same sweep zeroes the buffer before the first item is
// taken; attribute writes are taken at any time.
module text_console_cell_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // stream in
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] char_code, [18:8] cell_index, [23:19] zero
    input  logic [tccw_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] kind
    input  logic [tccw_pkg::KIND_W-1:0]    s_axis_tuser,
    // stream out
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [15:0] cell_value, [26:16] cursor_position, [31:27] zero
    output logic [tccw_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tccw_pkg::APB_AW-1:0]    paddr,
    input  logic [tccw_pkg::APB_DW-1:0]    pwdata,
    output logic [tccw_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    logic [tccw_pkg::ATTR_W-1:0]    r_attr;
    logic                           r_m_valid;
    logic [tccw_pkg::M_TDATA_W-1:0] r_m_data;

    tccw_pkg::t_item   item;
    tccw_pkg::t_result result;
    logic              core_idle;
    logic              core_done;
    logic              out_free;
    logic              start;

    // attribute register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tccw_pkg::ATTR_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr == tccw_pkg::ADDR_ATTRIBUTE)) begin
            r_attr <= pwdata[tccw_pkg::ATTR_W-1:0];
        end
    end
    assign prdata = (paddr == tccw_pkg::ADDR_ATTRIBUTE)
                    ? tccw_pkg::APB_DW'(r_attr) : '0;

    // input unpacking
    assign item.kind = s_axis_tuser;
    assign item.code = s_axis_tdata[tccw_pkg::CODE_W-1:0];
    assign item.idx  = s_axis_tdata[tccw_pkg::CODE_W +: tccw_pkg::IDX_W];

    assign s_axis_tready = core_idle;
    assign start         = s_axis_tvalid && core_idle;
    assign out_free      = !r_m_valid || m_axis_tready;

    tccw_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_item     (item),
        .i_attr     (r_attr),
        .i_out_free (out_free),
        .o_idle     (core_idle),
        .o_done     (core_done),
        .o_result   (result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (core_done) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
        if (core_done) begin
            r_m_data <= tccw_pkg::M_TDATA_W'({result.pos, result.value});
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

@@ tb/sv/tb_text_console_cell_writer_top.sv @@
module tb_text_console_cell_writer_top;
    import tccw_pkg::*;

    localparam int SCR_COLS   = 80;
    localparam int SCR_ROWS   = 25;
    localparam int CELL_COUNT = SCR_COLS * SCR_ROWS;
    localparam int CLK_PERIOD = 12;

    // kind code the block must ignore
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // scrolls and clears each walk the whole buffer; the
    // random part never goes past this many of them
    localparam int    SWEEP_BUDGET   = 250;
    localparam longint TIMEOUT_CYCLES = 4_000_000;
    localparam int    RANDOM_ITEMS   = 410;

    // output field positions in m_axis_tdata
    localparam int VAL_LSB = 0;
    localparam int POS_LSB = CELL_W;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [KIND_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_AW-1:0]     paddr         = '0;
    logic [APB_DW-1:0]     pwdata        = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    // shadow of the console state
    logic [CELL_W-1:0] shadow_screen [CELL_COUNT];
    int                shadow_col;
    int                shadow_row;
    logic [ATTR_W-1:0] shadow_attr;
    int                sweep_count;

    // results still owed by the block, oldest first
    t_result           pending_cells [$];
    t_result           want;

    int unsigned       send_idle_pct  = 0;
    int unsigned       recv_stall_pct = 0;
    int unsigned       rx_hold_left   = 0;
    int unsigned       error_count    = 0;

    text_console_cell_writer_top #(
        .COLUMNS (SCR_COLS),
        .ROWS    (SCR_ROWS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // clock
    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    task automatic report_error(input string what, input int unsigned exp_v,
                                input int unsigned got_v);
        $display("ERROR %s: expected 0x%0h, got 0x%0h at %0t", what, exp_v, got_v, $time);
        error_count++;
    endtask

    // cursor to column zero of the next row, scrolling past the bottom
    function automatic void start_next_row();
        shadow_col = 0;
        shadow_row++;
        if (shadow_row >= SCR_ROWS) begin
            for (int i = 0; i < CELL_COUNT - SCR_COLS; i++)
                shadow_screen[i] = shadow_screen[i + SCR_COLS];
            for (int i = CELL_COUNT - SCR_COLS; i < CELL_COUNT; i++)
                shadow_screen[i] = BLANK_CELL;
            shadow_row = SCR_ROWS - 1;
            sweep_count++;
        end
    endfunction

    // apply one transfer to the shadow state and return the result it owes
    function automatic t_result console_apply(input t_item it);
        t_result r;
        r.value = '0;
        case (it.kind)
            KIND_PUT: begin
                if (it.code == NEWLINE_CODE) begin
                    start_next_row();
                end else begin
                    shadow_screen[shadow_row * SCR_COLS + shadow_col] = {shadow_attr, it.code};
                    shadow_col++;
                    if (shadow_col >= SCR_COLS)
                        start_next_row();
                end
            end
            KIND_READ: begin
                if (it.idx < CELL_COUNT)
                    r.value = shadow_screen[it.idx];
            end
            KIND_CLEAR: begin
                for (int i = 0; i < CELL_COUNT; i++)
                    shadow_screen[i] = BLANK_CELL;
                shadow_col = 0;
                shadow_row = 0;
                sweep_count++;
            end
            default: ;
        endcase
        r.pos = POS_W'(shadow_row * SCR_COLS + shadow_col);
        return r;
    endfunction

    // offer one item and wait for its transfer; valid stays high afterwards
    task automatic send_item(input t_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({it.idx, it.code});
        s_axis_tuser  <= it.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_cells.push_back(console_apply(it));
    endtask

    task automatic send_fields(input logic [KIND_W-1:0] kind, input logic [CODE_W-1:0] code,
                               input logic [IDX_W-1:0] idx);
        t_item it;
        it.kind = kind;
        it.code = code;
        it.idx  = idx;
        send_item(it);
    endtask

    // drop valid and wait until every owed result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_cells.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic apb_write_attr(input logic [ATTR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ATTRIBUTE;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_attr = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // read the attribute register back and compare
    task automatic check_attribute();
        logic [APB_DW-1:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ATTRIBUTE;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (got[ATTR_W-1:0] !== shadow_attr)
            report_error("attribute readback", shadow_attr, got[ATTR_W-1:0]);
    endtask

    task automatic test_register_reset();
        check_attribute();
    endtask

    // field extremes, every kind, ignored fields, out-of-range reads
    task automatic test_directed_items();
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        apb_write_attr(8'hFF);
        check_attribute();
        send_fields(KIND_PUT, 8'h00, 11'h7FF);
        send_fields(KIND_PUT, 8'hFF, 11'h000);
        send_fields(KIND_PUT, 8'h55, 11'h2AA);
        send_fields(KIND_PUT, NEWLINE_CODE, 11'h555);
        send_fields(KIND_READ, 8'hFF, 11'd0);
        send_fields(KIND_READ, 8'h00, 11'd1);
        send_fields(KIND_READ, NEWLINE_CODE, 11'd2);
        send_fields(KIND_READ, 8'hAA, 11'd80);
        send_fields(KIND_UNUSED, 8'hFF, 11'h7FF);
        send_fields(KIND_UNUSED, NEWLINE_CODE, 11'h000);
        send_fields(KIND_READ, 8'h00, 11'd1999);
        send_fields(KIND_READ, 8'h00, 11'd2000);
        send_fields(KIND_READ, 8'h00, 11'h7FF);
        wait_drained();
        apb_write_attr(8'h00);
        send_fields(KIND_PUT, 8'h41, 11'h7FF);
        send_fields(KIND_READ, 8'h00, 11'd80);
        send_fields(KIND_CLEAR, NEWLINE_CODE, 11'h7FF);
        send_fields(KIND_READ, 8'h00, 11'd0);
        send_fields(KIND_READ, 8'h00, 11'd80);
        wait_drained();
        // clear leaves the attribute alone
        check_attribute();
        send_fields(KIND_PUT, 8'h42, 11'd0);
        send_fields(KIND_READ, 8'h00, 11'd0);
        wait_drained();
    endtask

    // fill every row, then scroll by newline and by wrapping the last row
    task automatic test_scroll();
        send_idle_pct  = 14;
        recv_stall_pct = 14;
        apb_write_attr(8'($urandom));
        send_fields(KIND_CLEAR, 8'h00, 11'd0);
        for (int r = 0; r < SCR_ROWS; r++) begin
            send_fields(KIND_PUT, 8'(8'h41 + r), 11'($urandom));
            if (r < SCR_ROWS - 1)
                send_fields(KIND_PUT, NEWLINE_CODE, 11'($urandom));
        end
        send_fields(KIND_PUT, NEWLINE_CODE, 11'($urandom));
        send_fields(KIND_READ, 8'h00, 11'd0);
        send_fields(KIND_READ, 8'h00, 11'(CELL_COUNT - 2 * SCR_COLS));
        send_fields(KIND_READ, 8'h00, 11'(CELL_COUNT - SCR_COLS));
        // wrap off the end of the last row
        repeat (SCR_COLS)
            send_fields(KIND_PUT, 8'($urandom_range(11, 255)), 11'($urandom));
        send_fields(KIND_READ, 8'h00, 11'(CELL_COUNT - 2 * SCR_COLS));
        send_fields(KIND_READ, 8'h00, 11'(CELL_COUNT - SCR_COLS - 1));
        send_fields(KIND_READ, 8'h00, 11'(CELL_COUNT - SCR_COLS));
        send_fields(KIND_READ, 8'h00, 11'(CELL_COUNT - 1));
        // newline at column zero of the last row scrolls in a blank row
        send_fields(KIND_PUT, NEWLINE_CODE, 11'($urandom));
        send_fields(KIND_READ, 8'h00, 11'(CELL_COUNT - 2 * SCR_COLS));
        repeat (12)
            send_fields(KIND_READ, 8'($urandom), 11'($urandom_range(0, CELL_COUNT - 1)));
        wait_drained();
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rx_hold_left   = 300;
        repeat (40) begin
            if ($urandom_range(0, 1) == 0)
                send_fields(KIND_PUT, 8'($urandom_range(11, 255)), 11'($urandom));
            else
                send_fields(KIND_READ, 8'($urandom), 11'($urandom_range(0, CELL_COUNT - 1)));
        end
        wait_drained();
    endtask

    task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input logic [ATTR_W-1:0] attr);
        t_item       it;
        int unsigned roll;
        int          back_pos;
        wait_drained();
        apb_write_attr(attr);
        check_attribute();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (RANDOM_ITEMS) begin
            it.code = 8'($urandom);
            it.idx  = 11'($urandom);
            roll    = $urandom_range(0, 999);
            if (roll < 660 || roll >= 940) begin
                it.kind = KIND_PUT;
                if (roll < 660 && $urandom_range(0, 99) < 22)
                    it.code = NEWLINE_CODE;
            end else if (roll < 880) begin
                it.kind = KIND_READ;
                case ($urandom_range(0, 3))
                    0, 1: it.idx = 11'($urandom_range(0, CELL_COUNT - 1));
                    2: begin
                        // just behind the cursor, where text was written
                        back_pos = shadow_row * SCR_COLS + shadow_col - $urandom_range(0, 160);
                        it.idx = 11'((back_pos < 0) ? 0 : back_pos);
                    end
                    default: ;
                endcase
            end else if (roll < 937) begin
                it.kind = KIND_UNUSED;
            end else begin
                it.kind = KIND_CLEAR;
            end
            // once the sweep budget is spent, no more scrolls or clears
            if (sweep_count >= SWEEP_BUDGET &&
                (it.kind == KIND_CLEAR ||
                 (it.kind == KIND_PUT && shadow_row == SCR_ROWS - 1 &&
                  (it.code == NEWLINE_CODE || shadow_col == SCR_COLS - 1))))
                it.kind = KIND_READ;
            send_item(it);
        end
        wait_drained();
    endtask

    // receiver ready, with random stalls and the long hold-off
    always @(posedge i_clk) begin
        if (rx_hold_left != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= rx_hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // compare each result transfer with the oldest owed result
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_cells.size() == 0) begin
                report_error("result with nothing owed", 0, m_axis_tdata);
            end else begin
                want = pending_cells.pop_front();
                if (m_axis_tdata[VAL_LSB +: CELL_W] !== want.value)
                    report_error("cell_value", want.value, m_axis_tdata[VAL_LSB +: CELL_W]);
                if (m_axis_tdata[POS_LSB +: POS_W] !== want.pos)
                    report_error("cursor_position", want.pos, m_axis_tdata[POS_LSB +: POS_W]);
            end
        end
    end

    // run limit
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("FAIL text_console_cell_writer_top");
        $finish;
    end

    // test sequence
    initial begin
        for (int i = 0; i < CELL_COUNT; i++)
            shadow_screen[i] = BLANK_CELL;
        shadow_col  = 0;
        shadow_row  = 0;
        shadow_attr = ATTR_RESET;
        sweep_count = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_register_reset();
        test_directed_items();
        test_scroll();
        test_backpressure();
        test_random_phase(0, 0, 8'h00);
        test_random_phase(48, 0, 8'hFF);
        test_random_phase(0, 48, 8'($urandom));
        test_random_phase(14, 14, 8'($urandom));

        wait_drained();
        repeat (64) @(posedge i_clk);
        if (pending_cells.size() != 0)
            report_error("results never arrived", 0, pending_cells.size());
        if (error_count == 0) begin
            $display("PASS text_console_cell_writer_top");
        end else begin
            $display("FAIL text_console_cell_writer_top");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tccw_pkg.sv
rtl/tccw_core.sv
rtl/text_console_cell_writer_top.sv
tb/sv/tb_text_console_cell_writer_top.sv
